FILE: rtl/rbbt_pkg.sv
// shared types, constants and register map of the rolling band breakout trader
`timescale 1ns / 1ps

package rbbt_pkg;

	localparam int WINDOW_MAX_DEF = 64;
	localparam int PRICE_BITS_DEF = 24;

	localparam int WL_W     = 7;
	localparam int MAXPOS_W = 8;
	localparam int BAND_W   = 4;
	localparam int POS_W    = MAXPOS_W + 1;
	localparam int PNL_W    = 48;
	localparam int ACT_W    = 2;

	localparam int OUT_FIELDS_W = ACT_W + POS_W + 2 * PNL_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam int REG_IDX_W  = CFG_ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_POSITION  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BAND_WIDTH    = 2'd2;

	localparam logic [WL_W-1:0]     WL_RST     = 7'd20;
	localparam logic [MAXPOS_W-1:0] MAXPOS_RST = 8'd5;
	localparam logic [BAND_W-1:0]   BAND_RST   = 4'd2;

	localparam logic signed [PNL_W-1:0] PNL_MAX = {1'b0, {(PNL_W-1){1'b1}}};
	localparam logic signed [PNL_W-1:0] PNL_MIN = {1'b1, {(PNL_W-1){1'b0}}};

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE = 2'd0,
		ACT_BUY  = 2'd1,
		ACT_SELL = 2'd2
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_OLD,
		ST_SQ_NEW,
		ST_SQ_SUM,
		ST_PROD,
		ST_VAR,
		ST_THR,
		ST_DECIDE,
		ST_MARK,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic [WL_W-1:0]     window_length;
		logic [MAXPOS_W-1:0] max_position;
		logic [BAND_W-1:0]   band_width;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic old_sq;
		logic new_sq;
		logic sum_sq;
		logic prod;
		logic var_sub;
		logic thr;
		logic decide;
		logic mark;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic full;
	} stat_t;

endpackage

FILE: rtl/rbbt_regs.sv
// configuration register file behind the apb-style port
`timescale 1ns / 1ps

module rbbt_regs
	import rbbt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg,
	output logic                  restart
);

	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;
	cfg_t                 cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign idx     = paddr[CFG_ADDR_W-1:2];
	assign restart = wr_en && (idx == REG_WINDOW_LENGTH);
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_length <= WL_RST;
			cfg_q.max_position  <= MAXPOS_RST;
			cfg_q.band_width    <= BAND_RST;
		end else if (wr_en) begin
			case (idx)
				REG_WINDOW_LENGTH: cfg_q.window_length <= pwdata[WL_W-1:0];
				REG_MAX_POSITION:  cfg_q.max_position  <= pwdata[MAXPOS_W-1:0];
				REG_BAND_WIDTH:    cfg_q.band_width    <= pwdata[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_WINDOW_LENGTH: prdata = CFG_DATA_W'(cfg_q.window_length);
			REG_MAX_POSITION:  prdata = CFG_DATA_W'(cfg_q.max_position);
			REG_BAND_WIDTH:    prdata = CFG_DATA_W'(cfg_q.band_width);
			default:           prdata = '0;
		endcase
	end

endmodule

FILE: rtl/rbbt_ctrl.sv
// sequencing state machine and output valid of the trader
`timescale 1ns / 1ps

module rbbt_ctrl
	import rbbt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	output logic  m_tvalid,
	input  logic  m_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SQ_OLD;
				end
			end
			ST_SQ_OLD: begin
				cmd.old_sq = 1'b1;
				state_d    = ST_SQ_NEW;
			end
			ST_SQ_NEW: begin
				cmd.new_sq = 1'b1;
				state_d    = ST_SQ_SUM;
			end
			ST_SQ_SUM: begin
				cmd.sum_sq = 1'b1;
				// warm-up items end here without a result
				state_d    = stat.full ? ST_PROD : ST_IDLE;
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d  = ST_VAR;
			end
			ST_VAR: begin
				cmd.var_sub = 1'b1;
				state_d     = ST_THR;
			end
			ST_THR: begin
				cmd.thr = 1'b1;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = ST_MARK;
			end
			ST_MARK: begin
				cmd.mark = 1'b1;
				state_d  = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: rtl/rbbt_dp.sv
// price ring, running sums, band test, position and pnl datapath
`timescale 1ns / 1ps

module rbbt_dp
	import rbbt_pkg::*;
#(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF,
	parameter int PRICE_BITS = PRICE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic                          restart,
	input  cmd_t                          cmd,
	input  logic [((PRICE_BITS+7)/8)*8-1:0] s_tdata,
	output stat_t                         stat,
	output logic [OUT_TDATA_W-1:0]        m_tdata
);

	localparam int PTR_W  = $clog2(WINDOW_MAX);
	localparam int CMP_W  = ((PTR_W + 1) > WL_W) ? (PTR_W + 1) : WL_W;
	localparam int SUM_W  = PRICE_BITS + WL_W;
	localparam int SQ_W   = 2 * PRICE_BITS + WL_W;
	localparam int DW     = 2 * SUM_W;
	localparam int PSQ_W  = 2 * BAND_W;
	localparam int THR_W  = DW + PSQ_W;
	localparam int PP_W   = PRICE_BITS + POS_W;
	localparam int SAT_W  = ((PP_W > PNL_W) ? PP_W : PNL_W) + 2;
	localparam int PAD_W  = OUT_TDATA_W - OUT_FIELDS_W;

	localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(PNL_MAX);
	localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(PNL_MIN);

	function automatic logic signed [PNL_W-1:0] sat_pnl(input logic signed [SAT_W-1:0] v);
		logic signed [PNL_W-1:0] r;
		if (v > SAT_HI) begin
			r = PNL_MAX;
		end else if (v < SAT_LO) begin
			r = PNL_MIN;
		end else begin
			r = v[PNL_W-1:0];
		end
		return r;
	endfunction

	// ring storage
	logic [PRICE_BITS-1:0] ring_mem [WINDOW_MAX];

	logic [WL_W-1:0]       n;
	logic [PTR_W-1:0]      ptr_q;
	logic [WL_W-1:0]       fill_q;
	logic [SUM_W-1:0]      sum_q;
	logic [SQ_W-1:0]       sumsq_q;
	logic signed [POS_W-1:0] pos_q;
	logic signed [PNL_W-1:0] cash_q;

	logic [PRICE_BITS-1:0] price_q;
	logic [PRICE_BITS-1:0] old_q;
	logic                  was_full_q;
	logic [SUM_W-1:0]      nprice_q;
	logic [SUM_W-1:0]      d_q;
	logic                  ge_q;
	logic                  le_q;
	logic [DW-1:0]         sq_q;
	logic [DW-1:0]         nsq_q;
	logic [DW-1:0]         sum2_q;
	logic [DW-1:0]         var_q;
	logic [THR_W-1:0]      thr_q;
	logic signed [PP_W-1:0] pp_q;
	action_t               action_q;

	action_t               out_action_q;
	logic [POS_W-1:0]      out_pos_q;
	logic [PNL_W-1:0]      out_cash_q;
	logic [PNL_W-1:0]      out_marked_q;

	logic [PRICE_BITS-1:0] in_price;
	logic                  full_now;
	logic [CMP_W-1:0]      ptr_inc;
	logic [PTR_W-1:0]      ptr_d;
	logic [PRICE_BITS-1:0] old_eff;
	logic [SUM_W-1:0]      sq_in;
	logic [DW-1:0]         sq_out;
	logic [PSQ_W-1:0]      psq;
	logic                  outside;
	logic signed [POS_W-1:0] lim;
	logic                  buy_ok;
	logic                  sell_ok;
	logic signed [SAT_W-1:0] cash_sx;
	logic signed [SAT_W-1:0] price_sx;
	logic signed [PP_W-1:0]  pos_w;
	logic signed [PP_W-1:0]  price_w;

	// effective window length
	always_comb begin
		if (cfg.window_length == '0) begin
			n = WL_W'(1);
		end else if (int'(cfg.window_length) > WINDOW_MAX) begin
			n = WL_W'(WINDOW_MAX);
		end else begin
			n = cfg.window_length;
		end
	end

	assign in_price  = s_tdata[PRICE_BITS-1:0];
	assign full_now  = fill_q >= n;
	assign stat.full = full_now;
	assign ptr_inc   = CMP_W'(ptr_q) + CMP_W'(1);
	assign ptr_d     = (ptr_inc >= CMP_W'(n)) ? '0 : ptr_inc[PTR_W-1:0];
	assign old_eff   = was_full_q ? old_q : '0;

	// shared squarer
	always_comb begin
		sq_in = '0;
		if (cmd.old_sq) begin
			sq_in = SUM_W'(old_eff);
		end else if (cmd.new_sq) begin
			sq_in = SUM_W'(price_q);
		end else if (cmd.sum_sq) begin
			sq_in = sum_q;
		end else if (cmd.prod) begin
			sq_in = d_q;
		end
	end

	assign sq_out = DW'(sq_in) * DW'(sq_in);
	assign psq    = PSQ_W'(cfg.band_width) * PSQ_W'(cfg.band_width);
	assign outside = THR_W'(sq_q) >= thr_q;

	assign lim     = signed'({1'b0, cfg.max_position});
	assign buy_ok  = pos_q < lim;
	assign sell_ok = pos_q > -lim;

	assign cash_sx  = SAT_W'(cash_q);
	assign price_sx = signed'(SAT_W'(price_q));
	assign pos_w    = PP_W'(pos_q);
	assign price_w  = signed'(PP_W'(price_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ring_mem[ptr_q] <= in_price;
			old_q           <= ring_mem[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
		end else if (restart) begin
			ptr_q   <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
		end else begin
			if (cmd.load) begin
				ptr_q <= ptr_d;
				if (!full_now) begin
					fill_q <= fill_q + WL_W'(1);
				end
			end
			if (cmd.old_sq) begin
				sum_q <= sum_q - SUM_W'(old_eff) + SUM_W'(price_q);
			end
			if (cmd.new_sq) begin
				sumsq_q <= sumsq_q - SQ_W'(sq_q);
			end
			if (cmd.sum_sq) begin
				sumsq_q <= sumsq_q + SQ_W'(sq_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			price_q    <= in_price;
			was_full_q <= full_now;
		end
		if (cmd.old_sq || cmd.new_sq || cmd.sum_sq || cmd.prod) begin
			sq_q <= sq_out;
		end
		if (cmd.old_sq) begin
			nprice_q <= SUM_W'(n) * SUM_W'(price_q);
		end
		if (cmd.sum_sq) begin
			ge_q <= nprice_q >= sum_q;
			le_q <= nprice_q <= sum_q;
			d_q  <= (nprice_q >= sum_q) ? nprice_q - sum_q : sum_q - nprice_q;
		end
		if (cmd.prod) begin
			nsq_q  <= DW'(sumsq_q) * DW'(n);
			sum2_q <= sq_q;
		end
		if (cmd.var_sub) begin
			var_q <= nsq_q - sum2_q;
		end
		if (cmd.thr) begin
			thr_q <= THR_W'(var_q) * THR_W'(psq);
		end
		if (cmd.mark) begin
			pp_q <= pos_w * price_w;
		end
		if (cmd.out_load) begin
			out_action_q <= action_q;
			out_pos_q    <= pos_q;
			out_cash_q   <= cash_q;
			out_marked_q <= sat_pnl(cash_sx + SAT_W'(pp_q));
		end
	end

	// trade decision, buy tried first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cash_q <= '0;
		end else if (cmd.decide) begin
			if (ge_q && outside && buy_ok) begin
				pos_q  <= pos_q + POS_W'(1);
				cash_q <= sat_pnl(cash_sx - price_sx);
			end else if (le_q && outside && sell_ok) begin
				pos_q  <= pos_q - POS_W'(1);
				cash_q <= sat_pnl(cash_sx + price_sx);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			if (ge_q && outside && buy_ok) begin
				action_q <= ACT_BUY;
			end else if (le_q && outside && sell_ok) begin
				action_q <= ACT_SELL;
			end else begin
				action_q <= ACT_NONE;
			end
		end
	end

	assign m_tdata = {{PAD_W{1'b0}}, out_marked_q, out_cash_q, out_pos_q, out_action_q};

endmodule

FILE: rtl/rolling_band_breakout_trader.sv
// top level of the rolling band breakout trader
`timescale 1ns / 1ps

// Usage:
// s_tdata carries one closing price in cents per transfer; the block keeps the
// last window_length prices in a ring memory, and their sum and sum of squares.
// Once the window is full each price yields one result on m_tdata: trade
// action, held position, cash pnl and marked pnl. Warm-up prices give none.
// Registers over the apb-style port: 0x0 window_length (a write restarts the
// window), 0x4 max_position, 0x8 band_width. Write them only while idle.
// Sequencing: s_tready is low from a transfer until the sequencer is idle again.
// For an item with a full window, m_tvalid and s_tready rise together when the
// final step loads the output register; a warm-up item returns to idle after
// the sum step. The sequencer steps one shared squarer through old price, new
// price, sum and distance, then runs the variance, threshold, decision and
// mark steps.
// The output register holds one result; the next item is taken while it waits.
// If the receiver stalls, the sequencer holds its final step until the output
// register frees, and s_tready stays low meanwhile.
// Reset clears the window, position and cash and loads the register defaults
// 20, 5 and 2; ring contents are not cleared and need no clearing pass.

module rolling_band_breakout_trader
	import rbbt_pkg::*;
#(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF,
	parameter int PRICE_BITS = PRICE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [((PRICE_BITS+7)/8)*8-1:0] s_tdata,  // close_price
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// trade_action, held_position, cash_pnl, marked_pnl
	output logic [OUT_TDATA_W-1:0]          m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [CFG_ADDR_W-1:0]           paddr,
	input  logic [CFG_DATA_W-1:0]           pwdata,
	output logic [CFG_DATA_W-1:0]           prdata,
	output logic                            pready
);

	cfg_t  cfg;
	logic  restart;
	cmd_t  cmd;
	stat_t stat;

	rbbt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.restart (restart)
	);

	rbbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rbbt_dp #(
		.WINDOW_MAX (WINDOW_MAX),
		.PRICE_BITS (PRICE_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.restart (restart),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.stat    (stat),
		.m_tdata (m_tdata)
	);

endmodule

FILE: rtl/rbbt_checker.sv
// port-level assertions for the trader and their bind to the top level
`timescale 1ns / 1ps

module rbbt_checker
	import rbbt_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	logic [ACT_W-1:0] act;
	logic [POS_W-1:0] pos;

	assign act = m_tdata[ACT_W-1:0];
	assign pos = m_tdata[ACT_W +: POS_W];

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_act_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (act == ACT_NONE) || (act == ACT_BUY) || (act == ACT_SELL))
		else $error("bad trade action code");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pos != {1'b1, {(POS_W-1){1'b0}}})
		else $error("held position out of range");

	// one item at a time
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result raised straight from idle");

endmodule

bind rolling_band_breakout_trader rbbt_checker u_rbbt_checker (.*);

FILE: bench/tb_rolling_band_breakout_trader.sv
// testbench for the rolling band breakout trader: directed and random price streams
`timescale 1ns / 1ps

module tb_rolling_band_breakout_trader;
	import rbbt_pkg::*;

	typedef struct {
		action_t                 act;
		logic signed [POS_W-1:0] held;
		logic signed [PNL_W-1:0] cash;
		logic signed [PNL_W-1:0] marked;
	} trade_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [23:0]            s_tdata;  // close_price
	logic                   m_tvalid;
	logic                   m_tready;
	// trade_action, held_position, cash_pnl, marked_pnl
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [CFG_ADDR_W-1:0]  paddr;
	logic [CFG_DATA_W-1:0]  pwdata;
	logic [CFG_DATA_W-1:0]  prdata;
	logic                   pready;

	rolling_band_breakout_trader dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// band and book state of the predictor
	logic [23:0]         price_hist [0:WINDOW_MAX_DEF-1];
	int unsigned         hist_ptr;
	int unsigned         hist_fill;
	logic [127:0]        band_sum;
	logic [127:0]        band_sq_sum;
	int                  units_held;
	longint              cash_acc;
	logic [WL_W-1:0]     cfg_window;
	logic [MAXPOS_W-1:0] cfg_max_units;
	logic [BAND_W-1:0]   cfg_band;

	trade_t expected_trades [$];
	int     err_count;
	bit     quiet_run;
	int     walk_level;

	initial begin
		clk = 1'b0;
	end

	always #6 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= quiet_run || ($urandom_range(99) >= 21);
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		err_count++;
		if (err_count <= 40)
			$display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
	endtask

	function automatic longint clamp48(input longint v);
		if (v > longint'(PNL_MAX))
			return longint'(PNL_MAX);
		if (v < longint'(PNL_MIN))
			return longint'(PNL_MIN);
		return v;
	endfunction

	function automatic void predict_trade(input logic [23:0] price);
		int unsigned  n;
		int unsigned  slot;
		logic [127:0] n_price;
		logic [127:0] gap;
		logic [127:0] spread;
		logic [127:0] limit;
		bit           above;
		bit           below;
		bit           outside;
		longint       marked_val;
		trade_t       t;
		if (cfg_window == 0)
			n = 1;
		else if (cfg_window > WINDOW_MAX_DEF)
			n = WINDOW_MAX_DEF;
		else
			n = cfg_window;
		slot = hist_ptr % n;
		if (hist_fill >= n) begin
			band_sum = band_sum - 128'(price_hist[slot]);
			band_sq_sum = band_sq_sum - 128'(price_hist[slot]) * 128'(price_hist[slot]);
		end else begin
			hist_fill++;
		end
		price_hist[slot] = price;
		band_sum = band_sum + 128'(price);
		band_sq_sum = band_sq_sum + 128'(price) * 128'(price);
		hist_ptr = (slot + 1 >= n) ? 0 : slot + 1;
		if (hist_fill < n)
			return;

		n_price = 128'(n) * 128'(price);
		above = n_price >= band_sum;
		below = n_price <= band_sum;
		gap = above ? n_price - band_sum : band_sum - n_price;
		spread = 128'(n) * band_sq_sum - band_sum * band_sum;
		limit = spread * 128'(cfg_band) * 128'(cfg_band);
		outside = gap * gap >= limit;

		t.act = ACT_NONE;
		if (above && outside && units_held < int'(cfg_max_units)) begin
			t.act = ACT_BUY;
			units_held++;
			cash_acc = clamp48(cash_acc - longint'(price));
		end else if (below && outside && units_held > -int'(cfg_max_units)) begin
			t.act = ACT_SELL;
			units_held--;
			cash_acc = clamp48(cash_acc + longint'(price));
		end
		marked_val = clamp48(cash_acc + longint'(units_held) * longint'(price));
		t.held = units_held[POS_W-1:0];
		t.cash = cash_acc[PNL_W-1:0];
		t.marked = marked_val[PNL_W-1:0];
		expected_trades.insert(expected_trades.size(), t);
	endfunction

	always @(posedge clk) begin : result_check
		trade_t got;
		trade_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.act = action_t'(m_tdata[ACT_W-1:0]);
			got.held = m_tdata[ACT_W +: POS_W];
			got.cash = m_tdata[ACT_W + POS_W +: PNL_W];
			got.marked = m_tdata[ACT_W + POS_W + PNL_W +: PNL_W];
			if (expected_trades.size() == 0) begin
				report_mismatch("unexpected result, trade_action", got.act, -1);
			end else begin
				want = expected_trades.pop_front();
				if (got.act !== want.act)
					report_mismatch("trade_action", got.act, want.act);
				if (got.held !== want.held)
					report_mismatch("held_position", longint'(got.held), longint'(want.held));
				if (got.cash !== want.cash)
					report_mismatch("cash_pnl", longint'(got.cash), longint'(want.cash));
				if (got.marked !== want.marked)
					report_mismatch("marked_pnl", longint'(got.marked), longint'(want.marked));
			end
		end
	end

	task automatic send_price(input logic [23:0] price);
		@(negedge clk);
		while (!quiet_run && $urandom_range(99) < 21) begin
			s_tvalid <= 1'b0;
			s_tdata <= 24'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= price;
		do @(posedge clk); while (!s_tready);
		predict_trade(price);
	endtask

	task automatic drain_results();
		int spins;
		@(negedge clk);
		s_tvalid <= 1'b0;
		spins = 0;
		while (expected_trades.size() != 0 && spins < 4000) begin
			@(posedge clk);
			spins++;
		end
		if (expected_trades.size() != 0) begin
			report_mismatch("results never delivered", expected_trades.size(), 0);
			expected_trades.delete();
		end
		repeat (16) @(posedge clk);
	endtask

	task automatic check_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			report_mismatch("register readback", prdata, want);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		logic [31:0] stored;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		stored = 0;
		case (idx)
			REG_WINDOW_LENGTH: begin
				cfg_window = value[WL_W-1:0];
				stored[WL_W-1:0] = cfg_window;
				// a window write starts the band over, the book is kept
				hist_ptr = 0;
				hist_fill = 0;
				band_sum = 0;
				band_sq_sum = 0;
			end
			REG_MAX_POSITION: begin
				cfg_max_units = value[MAXPOS_W-1:0];
				stored[MAXPOS_W-1:0] = cfg_max_units;
			end
			REG_BAND_WIDTH: begin
				cfg_band = value[BAND_W-1:0];
				stored[BAND_W-1:0] = cfg_band;
			end
			default: begin
			end
		endcase
		check_reg(idx, stored);
	endtask

	function automatic logic [23:0] next_price();
		int roll;
		roll = $urandom_range(99);
		if (roll < 3)
			walk_level = $urandom_range(1) ? 24'hFFFFFF : 0;
		else if (roll < 12)
			return 24'($urandom);
		else if (roll < 22)
			walk_level = walk_level + int'($urandom_range(40000)) - 20000;
		else
			walk_level = walk_level + int'($urandom_range(600)) - 300;
		if (walk_level < 0)
			walk_level = 0;
		if (walk_level > 24'hFFFFFF)
			walk_level = 24'hFFFFFF;
		return 24'(walk_level);
	endfunction

	task automatic run_band_phase(input int wl, input int mp, input int bw, input int count);
		drain_results();
		program_reg(REG_WINDOW_LENGTH, 32'(wl));
		program_reg(REG_MAX_POSITION, 32'(mp));
		program_reg(REG_BAND_WIDTH, 32'(bw));
		repeat (count) send_price(next_price());
	endtask

	task automatic test_reset_values();
		check_reg(REG_WINDOW_LENGTH, 32'(WL_RST));
		check_reg(REG_MAX_POSITION, 32'(MAXPOS_RST));
		check_reg(REG_BAND_WIDTH, 32'(BAND_RST));
	endtask

	// window zero acts as one: zero variance, every price sits on both bands
	task automatic test_single_price_window();
		program_reg(REG_WINDOW_LENGTH, 0);
		program_reg(REG_BAND_WIDTH, 0);
		send_price(24'h000000);
		send_price(24'hFFFFFF);
		send_price(24'h800000);
		send_price(24'h7FFFFF);
		send_price(24'h000001);
		send_price(24'hAAAAAA);
		send_price(24'h555555);
	endtask

	// holdings above a lowered limit may only shrink
	task automatic test_position_limits();
		drain_results();
		program_reg(REG_MAX_POSITION, 1);
		program_reg(REG_WINDOW_LENGTH, 2);
		send_price(24'd100);
		send_price(24'd200);
		send_price(24'd300);
		send_price(24'd50);
		send_price(24'd40);
		drain_results();
		program_reg(REG_MAX_POSITION, 0);
		send_price(24'd30);
		send_price(24'd1000);
	endtask

	task automatic test_wide_band();
		drain_results();
		program_reg(REG_WINDOW_LENGTH, 4);
		program_reg(REG_MAX_POSITION, 3);
		program_reg(REG_BAND_WIDTH, 15);
		repeat (4) send_price(24'd1000);
		send_price(24'd1001);
		send_price(24'hFFFFFF);
	endtask

	task automatic test_random_bands();
		run_band_phase(8, 5, 2, 45);
		// hold the sender until the block has emptied
		drain_results();
		repeat (45) send_price(next_price());
		quiet_run = 1'b1;
		run_band_phase(3, 255, 0, 60);
		drain_results();
		quiet_run = 1'b0;
		run_band_phase(127, 3, 1, 100);
		run_band_phase(64, 0, 15, 80);
		run_band_phase(1, 10, 7, 40);
		repeat (3)
			run_band_phase($urandom_range(2, 20), $urandom_range(0, 255),
				$urandom_range(0, 15), 60);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hist_ptr = 0;
		hist_fill = 0;
		band_sum = 0;
		band_sq_sum = 0;
		units_held = 0;
		cash_acc = 0;
		cfg_window = WL_RST;
		cfg_max_units = MAXPOS_RST;
		cfg_band = BAND_RST;
		err_count = 0;
		quiet_run = 1'b0;
		walk_level = 5000000;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_single_price_window();
		test_position_limits();
		test_wide_band();
		test_random_bands();
		drain_results();

		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

endmodule

FILE: rolling_band_breakout_trader.f
rtl/rbbt_pkg.sv
rtl/rbbt_regs.sv
rtl/rbbt_ctrl.sv
rtl/rbbt_dp.sv
rtl/rolling_band_breakout_trader.sv
rtl/rbbt_checker.sv
bench/tb_rolling_band_breakout_trader.sv
